// ===== rtl/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and constants of the moving average crossover block.
// ----------------------------------------------------------------------------
package mac_pkg;

	localparam int PRICE_W   = 32;
	localparam int INDEX_W   = 32;
	localparam int CFG_BITS  = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = CFG_IDX_W'(1);

	localparam logic [CFG_BITS-1:0] SHORT_RESET = CFG_BITS'(10);
	localparam logic [CFG_BITS-1:0] LONG_RESET  = CFG_BITS'(50);

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_BUY  = 2'd1,
		ACT_SELL = 2'd2
	} action_t;

	// Control of a delay line: advance on a price transfer, clear on restart.
	typedef struct packed {
		logic shift;
		logic clear;
	} line_ctrl_t;

endpackage

// ===== rtl/mac_cell.sv =====
// ----------------------------------------------------------------------------
// mac_cell
// One stage of a variable length delay line with an injection point.
// ----------------------------------------------------------------------------
module mac_cell #(
	parameter int IDX       = 0,
	parameter int WIN_BITS  = 9,
	parameter int DATA_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_pkg::line_ctrl_t     ctrl,
	input  logic [WIN_BITS-1:0]     window,
	input  logic [DATA_BITS-1:0]    sample,
	input  logic [DATA_BITS-1:0]    next_data,
	input  logic                    next_valid,
	output logic [DATA_BITS-1:0]    data,
	output logic                    valid
);
	import mac_pkg::*;

	localparam logic [WIN_BITS-1:0] TAP = WIN_BITS'(IDX + 1);

	logic                 inject;
	logic [DATA_BITS-1:0] data_q;
	logic                 valid_q;

	// The new sample enters at the cell that is window-1 steps from the head,
	// so it reaches the head exactly window transfers later.
	assign inject = (window == TAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= inject ? 1'b1 : next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= inject ? sample : next_data;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

// ===== rtl/mac_line.sv =====
// ----------------------------------------------------------------------------
// mac_line
// Row of delay cells that returns the sample leaving a window of given length.
// ----------------------------------------------------------------------------
module mac_line #(
	parameter int DEPTH     = 256,
	parameter int WIN_BITS  = 9,
	parameter int DATA_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_pkg::line_ctrl_t     ctrl,
	input  logic [WIN_BITS-1:0]     window,
	input  logic [DATA_BITS-1:0]    sample,
	output logic [DATA_BITS-1:0]    oldest
);
	import mac_pkg::*;

	logic [DATA_BITS-1:0] cell_data  [DEPTH+1];
	logic                 cell_valid [DEPTH+1];

	assign cell_data[DEPTH]  = '0;
	assign cell_valid[DEPTH] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mac_cell #(
			.IDX       (i),
			.WIN_BITS  (WIN_BITS),
			.DATA_BITS (DATA_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.window     (window),
			.sample     (sample),
			.next_data  (cell_data[i+1]),
			.next_valid (cell_valid[i+1]),
			.data       (cell_data[i]),
			.valid      (cell_valid[i])
		);
	end

	// A slot never filled since the last restart counts as a zero price.
	assign oldest = cell_valid[0] ? cell_data[0] : '0;

endmodule

// ===== rtl/moving_average_crossover_core.sv =====
// ----------------------------------------------------------------------------
// moving_average_crossover_core
// Dual simple moving average crossover: buy and sell signals per price.
// ----------------------------------------------------------------------------
// Takes one price per cycle while in_ready is high (the output is not
// stalled) and returns one result per price. The three stages are the
// running sum update with the delay lines, the cross-multiplication of the two
// sums by the opposite window lengths, and the compare that updates the
// position flag. Each window has its own row of MAX_WINDOW delay cells in
// which the newest price enters at the cell set by the window length, so the
// price that leaves the window always appears at the head of the row. Any
// write to the short or long window register restarts the stream: sums,
// sample count, warm-up and position return to zero; write only while idle.
module moving_average_crossover_core #(
	parameter int MAX_WINDOW = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [mac_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mac_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mac_pkg::PRICE_W-1:0]           price,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output mac_pkg::action_t                      action,
	output logic [mac_pkg::INDEX_W-1:0]           sample_index,
	output logic [mac_pkg::PRICE_W-1:0]           echo_price
);
	import mac_pkg::*;

	localparam int SAMPLE_BITS = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
	localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int CMP_BITS    = (CFG_BITS > WIN_BITS) ? CFG_BITS : WIN_BITS;
	localparam int SUM_BITS    = SAMPLE_BITS + WIN_BITS;
	localparam int PROD_BITS   = SUM_BITS + WIN_BITS;

	// Configuration
	logic [CFG_BITS-1:0] short_q;
	logic [CFG_BITS-1:0] long_q;
	logic                restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= SHORT_RESET;
			long_q  <= LONG_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == REG_SHORT_WINDOW) begin
				short_q <= cfg_data;
			end
			if (cfg_index == REG_LONG_WINDOW) begin
				long_q <= cfg_data;
			end
		end
	end

	assign restart = cfg_write_en &&
		(cfg_index == REG_SHORT_WINDOW || cfg_index == REG_LONG_WINDOW);

	// Effective window lengths: zero acts as one, and both are capped by the
	// line depth; the short window never exceeds the long one.
	logic [CMP_BITS-1:0] short_c;
	logic [CMP_BITS-1:0] long_c;
	logic [WIN_BITS-1:0] lw;
	logic [WIN_BITS-1:0] sw_cap;
	logic [WIN_BITS-1:0] sw;

	assign short_c = CMP_BITS'(short_q);
	assign long_c  = CMP_BITS'(long_q);

	always_comb begin
		priority if (long_c == '0) begin
			lw = WIN_BITS'(1);
		end else if (long_c > CMP_BITS'(MAX_WINDOW)) begin
			lw = WIN_BITS'(MAX_WINDOW);
		end else begin
			lw = WIN_BITS'(long_c);
		end
		priority if (short_c == '0) begin
			sw_cap = WIN_BITS'(1);
		end else if (short_c > CMP_BITS'(MAX_WINDOW)) begin
			sw_cap = WIN_BITS'(MAX_WINDOW);
		end else begin
			sw_cap = WIN_BITS'(short_c);
		end
		sw = (sw_cap > lw) ? lw : sw_cap;
	end

	// Pipeline flow control
	logic v1_q, v2_q, v3_q;
	logic rdy1, rdy2, rdy3;
	logic accept, load2, load3;

	assign rdy3     = !v3_q || out_ready;
	assign load3    = v2_q && rdy3;
	assign rdy2     = !v2_q || rdy3;
	assign load2    = v1_q && rdy2;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= accept ? 1'b1 : (load2 ? 1'b0 : v1_q);
			v2_q <= load2 ? 1'b1 : (load3 ? 1'b0 : v2_q);
			v3_q <= load3 ? 1'b1 : (out_ready ? 1'b0 : v3_q);
		end
	end

	// Stage 1: delay lines and running sums
	logic [SAMPLE_BITS-1:0] p;
	line_ctrl_t             line_ctrl;
	logic [SAMPLE_BITS-1:0] old_fast;
	logic [SAMPLE_BITS-1:0] old_slow;

	assign p               = price[SAMPLE_BITS-1:0];
	assign line_ctrl.shift = accept;
	assign line_ctrl.clear = restart;

	mac_line #(
		.DEPTH     (MAX_WINDOW),
		.WIN_BITS  (WIN_BITS),
		.DATA_BITS (SAMPLE_BITS)
	) u_fast_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (line_ctrl),
		.window (sw),
		.sample (p),
		.oldest (old_fast)
	);

	mac_line #(
		.DEPTH     (MAX_WINDOW),
		.WIN_BITS  (WIN_BITS),
		.DATA_BITS (SAMPLE_BITS)
	) u_slow_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (line_ctrl),
		.window (lw),
		.sample (p),
		.oldest (old_slow)
	);

	logic [SUM_BITS-1:0]    fast_sum_q;
	logic [SUM_BITS-1:0]    slow_sum_q;
	logic [INDEX_W-1:0]     seen_q;
	logic                   warm_q;
	logic [SUM_BITS-1:0]    fast_next;
	logic [SUM_BITS-1:0]    slow_next;
	logic                   warm_next;

	assign fast_next = fast_sum_q + SUM_BITS'(p) - SUM_BITS'(old_fast);
	assign slow_next = slow_sum_q + SUM_BITS'(p) - SUM_BITS'(old_slow);
	assign warm_next = warm_q ||
		((INDEX_W + 1)'(seen_q) + (INDEX_W + 1)'(1) >= (INDEX_W + 1)'(lw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_sum_q <= '0;
			slow_sum_q <= '0;
			seen_q     <= '0;
			warm_q     <= 1'b0;
		end else if (restart) begin
			fast_sum_q <= '0;
			slow_sum_q <= '0;
			seen_q     <= '0;
			warm_q     <= 1'b0;
		end else if (accept) begin
			fast_sum_q <= fast_next;
			slow_sum_q <= slow_next;
			seen_q     <= seen_q + INDEX_W'(1);
			warm_q     <= warm_next;
		end
	end

	logic [SUM_BITS-1:0]    fast_s1;
	logic [SUM_BITS-1:0]    slow_s1;
	logic                   warm_s1;
	logic [INDEX_W-1:0]     idx_s1;
	logic [SAMPLE_BITS-1:0] price_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			fast_s1  <= fast_next;
			slow_s1  <= slow_next;
			warm_s1  <= warm_next;
			idx_s1   <= seen_q;
			price_s1 <= p;
		end
	end

	// Stage 2: cross-multiply so the averages compare without a division
	logic [PROD_BITS-1:0]   fast_prod_s2;
	logic [PROD_BITS-1:0]   slow_prod_s2;
	logic                   warm_s2;
	logic [INDEX_W-1:0]     idx_s2;
	logic [SAMPLE_BITS-1:0] price_s2;

	always_ff @(posedge clk) begin
		if (load2) begin
			fast_prod_s2 <= PROD_BITS'(fast_s1) * PROD_BITS'(lw);
			slow_prod_s2 <= PROD_BITS'(slow_s1) * PROD_BITS'(sw);
			warm_s2      <= warm_s1;
			idx_s2       <= idx_s1;
			price_s2     <= price_s1;
		end
	end

	// Stage 3: decision and position flag
	logic    holding_q;
	action_t act_d;
	logic    holding_d;

	always_comb begin
		act_d     = ACT_NONE;
		holding_d = holding_q;
		if (warm_s2) begin
			if (!holding_q && fast_prod_s2 > slow_prod_s2) begin
				act_d     = ACT_BUY;
				holding_d = 1'b1;
			end else if (holding_q && fast_prod_s2 < slow_prod_s2) begin
				act_d     = ACT_SELL;
				holding_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
		end else if (restart) begin
			holding_q <= 1'b0;
		end else if (load3) begin
			holding_q <= holding_d;
		end
	end

	action_t                act_s3;
	logic [INDEX_W-1:0]     idx_s3;
	logic [SAMPLE_BITS-1:0] price_s3;

	always_ff @(posedge clk) begin
		if (load3) begin
			act_s3   <= act_d;
			idx_s3   <= idx_s2;
			price_s3 <= price_s2;
		end
	end

	assign out_valid    = v3_q;
	assign action       = act_s3;
	assign sample_index = idx_s3;
	assign echo_price   = PRICE_W'(price_s3);

	// The short window sum covers a subset of the long window samples.
	a_fast_within_slow: assert property (@(posedge clk) disable iff (!arst_n)
		fast_sum_q <= slow_sum_q)
		else $error("fast window sum exceeds slow window sum");

	a_buy_takes_position: assert property (@(posedge clk) disable iff (!arst_n)
		load3 && act_d == ACT_BUY |=> holding_q)
		else $error("buy transfer did not take the position");

	a_no_signal_in_warmup: assert property (@(posedge clk) disable iff (!arst_n)
		load3 && !warm_s2 |=> act_s3 == ACT_NONE)
		else $error("signal issued before warm-up completed");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v1_q && v2_q && v3_q)
		else $error("input stalled while the pipeline has room");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the moving average crossover core.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own delay line, window sums, warm-up and
// position flags, and predicts the action, index and echoed price of every
// price transfer. Results are checked in order against that prediction. The
// run starts on the reset windows, goes through a short directed part with
// extreme prices and window edge cases, then through random phases whose
// prices follow trending walks mixed with full-range noise. Both handshakes
// idle at random, except in one phase that runs without gaps.
// ----------------------------------------------------------------------------
module tb;
	import mac_pkg::*;

	localparam int IDLE_PCT   = 22;
	localparam int WATCHDOG   = 2000;
	localparam int TAIL_WAIT  = 10;
	localparam int WIN_DEPTH  = 256;

	// Indexes past the register list; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = CFG_IDX_W'(3);

	typedef struct {
		action_t             act;
		logic [INDEX_W-1:0]  idx;
		logic [PRICE_W-1:0]  px;
	} crossover_result_t;

	class crossover_scoreboard;
		logic [PRICE_W-1:0]  price_line [WIN_DEPTH];
		logic [7:0]          wr_ptr;
		logic [39:0]         fast_sum;
		logic [39:0]         slow_sum;
		logic [INDEX_W-1:0]  seen;
		bit                  warm;
		bit                  holding;
		logic [CFG_BITS-1:0] short_reg;
		logic [CFG_BITS-1:0] long_reg;
		crossover_result_t   pending_results [$];
		int                  errors;
		int                  checked;
		int                  buys;
		int                  sells;

		function new();
			short_reg = SHORT_RESET;
			long_reg  = LONG_RESET;
			errors    = 0;
			checked   = 0;
			buys      = 0;
			sells     = 0;
			restart();
		endfunction

		function void restart();
			foreach (price_line[i]) price_line[i] = '0;
			wr_ptr   = '0;
			fast_sum = '0;
			slow_sum = '0;
			seen     = '0;
			warm     = 1'b0;
			holding  = 1'b0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] val);
			if (idx == REG_SHORT_WINDOW) begin
				short_reg = val;
				restart();
			end else if (idx == REG_LONG_WINDOW) begin
				long_reg = val;
				restart();
			end
		endfunction

		function int unsigned window_len(logic [CFG_BITS-1:0] w);
			if (w == 0)
				return 1;
			if (w > WIN_DEPTH)
				return WIN_DEPTH;
			return w;
		endfunction

		function void note_price(logic [PRICE_W-1:0] p);
			int unsigned       lw;
			int unsigned       sw;
			logic [7:0]        old_s;
			logic [7:0]        old_l;
			logic [63:0]       lhs;
			logic [63:0]       rhs;
			crossover_result_t r;
			lw = window_len(long_reg);
			sw = window_len(short_reg);
			if (sw > lw)
				sw = lw;
			// A full window of 256 wraps onto the slot about to be overwritten.
			old_s = wr_ptr - 8'(sw);
			old_l = wr_ptr - 8'(lw);
			fast_sum = fast_sum + 40'(p) - 40'(price_line[old_s]);
			slow_sum = slow_sum + 40'(p) - 40'(price_line[old_l]);
			price_line[wr_ptr] = p;
			wr_ptr = wr_ptr + 8'd1;
			r.idx = seen;
			r.px  = p;
			r.act = ACT_NONE;
			seen = seen + 1;
			if (!warm && (64'(r.idx) + 64'd1 >= 64'(lw)))
				warm = 1'b1;
			if (warm) begin
				lhs = 64'(fast_sum) * 64'(lw);
				rhs = 64'(slow_sum) * 64'(sw);
				if (!holding && lhs > rhs) begin
					r.act   = ACT_BUY;
					holding = 1'b1;
					buys++;
				end else if (holding && lhs < rhs) begin
					r.act   = ACT_SELL;
					holding = 1'b0;
					sells++;
				end
			end
			pending_results = {pending_results, r};
		endfunction

		function void check_result(action_t act, logic [INDEX_W-1:0] idx,
				logic [PRICE_W-1:0] px);
			crossover_result_t r;
			if (pending_results.size() == 0) begin
				$error("result with no pending prediction: action %0d index %0d price %h",
					act, idx, px);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			checked++;
			if (act !== r.act) begin
				$error("action: expected %0d, actual %0d", r.act, act);
				errors++;
			end
			if (idx !== r.idx) begin
				$error("sample_index: expected %0d, actual %0d", r.idx, idx);
				errors++;
			end
			if (px !== r.px) begin
				$error("echo_price: expected %h, actual %h", r.px, px);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_BITS-1:0]  cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PRICE_W-1:0]   price;
	logic                 out_valid;
	logic                 out_ready;
	action_t              action;
	logic [INDEX_W-1:0]   sample_index;
	logic [PRICE_W-1:0]   echo_price;

	crossover_scoreboard  sb;
	bit                   quiet;
	logic [PRICE_W-1:0]   walk_price;
	int                   trend;
	int                   n_prices;
	int                   n_settings;

	moving_average_crossover_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.price        (price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.sample_index (sample_index),
		.echo_price   (echo_price)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(action, sample_index, echo_price);
	end

	// Ends the run when no transfer or register write happens for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_BITS-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		sb.write_register(idx, val);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_price(input logic [PRICE_W-1:0] p);
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		price    <= p;
		do @(posedge clk); while (!in_ready);
		sb.note_price(p);
		n_prices++;
	endtask

	// Holds the sender until every predicted result has been checked.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input logic [CFG_BITS-1:0] short_len,
			input logic [CFG_BITS-1:0] long_len, input int count, input bit no_idle,
			input bit hold_mid, input bit keep_cfg);
		int                 sel;
		logic [PRICE_W-1:0] p;
		drain();
		if (!keep_cfg) begin
			write_register(REG_SHORT_WINDOW, short_len);
			write_register(REG_LONG_WINDOW, long_len);
		end
		n_settings++;
		quiet = no_idle;
		for (int k = 0; k < count; k++) begin
			if (hold_mid && k == count / 2)
				drain();
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				p = $urandom;
			end else if (sel < 16) begin
				p = $urandom_range(0, 1) ? '1 : '0;
			end else begin
				// Trending walk with noise, so the averages actually cross.
				if ($urandom_range(0, 99) < 4)
					trend = int'($urandom_range(0, 4000)) - 2000;
				walk_price = walk_price + PRICE_W'(trend)
					+ PRICE_W'(int'($urandom_range(0, 400)) - 200);
				p = walk_price;
			end
			send_price(p);
		end
		quiet = 1'b0;
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		price        = '0;
		out_ready    = 1'b0;
		quiet        = 1'b0;
		walk_price   = 32'h0001_0000;
		trend        = 300;
		n_prices     = 0;
		n_settings   = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset windows first, before any register write.
		run_random(SHORT_RESET, LONG_RESET, 120, 1'b0, 1'b0, 1'b1);

		// Directed: extreme prices, a buy and a sell, equal averages.
		drain();
		write_register(REG_SHORT_WINDOW, 9'd2);
		write_register(REG_LONG_WINDOW, 9'd4);
		n_settings++;
		send_price('0);
		send_price('1);
		send_price('1);
		send_price('1);
		send_price('0);
		send_price('0);
		send_price(32'd100);
		send_price(32'd200);
		send_price(32'd300);
		send_price(32'd50);
		send_price(32'd40);
		send_price(32'd30);
		// Writes past the register list must not restart the stream.
		drain();
		write_register(REG_SPARE_LOW, 9'h1FF);
		write_register(REG_SPARE_HIGH, 9'h0AA);
		send_price(32'd500);
		send_price(32'd600);
		send_price(32'd10);
		// Zero windows act as one, so both averages are always equal.
		drain();
		write_register(REG_SHORT_WINDOW, 9'd0);
		write_register(REG_LONG_WINDOW, 9'd0);
		n_settings++;
		send_price(32'hDEAD_BEEF);
		send_price(32'h0000_0001);
		send_price('1);
		// A short window above the long one is clamped to it.
		drain();
		write_register(REG_SHORT_WINDOW, 9'h1FF);
		write_register(REG_LONG_WINDOW, 9'd3);
		n_settings++;
		send_price(32'd7);
		send_price(32'd900);
		send_price(32'd3);
		send_price(32'hFFFF_0000);

		run_random(9'd3, 9'd12, 150, 1'b0, 1'b0, 1'b0);
		run_random(9'd1, 9'd2, 80, 1'b1, 1'b0, 1'b0);
		// A long window past the delay line depth acts as the full depth.
		run_random(9'd40, 9'h1FF, 300, 1'b0, 1'b0, 1'b0);
		run_random(9'd7, 9'd30, 150, 1'b0, 1'b1, 1'b0);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d predicted results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Sent %0d prices across %0d window settings, %0d results checked.",
			n_prices, n_settings, sb.checked);
		$display("Predicted %0d buy and %0d sell signals along the way.", sb.buys, sb.sells);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
